// File: hdl/tiis_pkg.sv
`default_nettype none

package tiis_pkg;

    localparam int CMD_W = 16;
    localparam int AMP_W = 16;
    localparam int DLY_W = 8;
    localparam int SLOT_W = 19;
    localparam int SCL_W = 18;
    localparam int PROD_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] REG_AMP_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_THIRD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_THIRD = 3'd4;

    localparam logic signed [AMP_W-1:0] AMP_FIRST_RST = 16'sd4096;
    localparam logic signed [AMP_W-1:0] AMP_SECOND_RST = 16'sd8192;
    localparam logic signed [AMP_W-1:0] AMP_THIRD_RST = 16'sd4096;
    localparam logic [DLY_W-1:0] DELAY_SECOND_RST = 8'd25;
    localparam logic [DLY_W-1:0] DELAY_THIRD_RST = 8'd50;

    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_SECOND = 2'd1;
    localparam logic [1:0] OP_THIRD = 2'd2;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic signed [SCL_W-1:0] scaled;
    } t_op;

    typedef struct packed {
        logic signed [CMD_W-1:0] command_out;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out payload;
    } t_res;

endpackage

`default_nettype wire

// File: hdl/tiis_seq.sv
`default_nettype none

module tiis_seq #(
    parameter int BUFFER_DEPTH = tiis_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_accept,
    input  wire logic signed [tiis_pkg::CMD_W-1:0]     i_command_in,
    input  wire logic signed [tiis_pkg::AMP_W-1:0]     i_amp_first,
    input  wire logic signed [tiis_pkg::AMP_W-1:0]     i_amp_second,
    input  wire logic signed [tiis_pkg::AMP_W-1:0]     i_amp_third,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0]       i_dly_second,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0]       i_dly_third,
    output logic                                       o_can_take,
    output tiis_pkg::t_op                              o_op,
    output logic [$clog2(BUFFER_DEPTH)-1:0]            o_op_addr
);

    import tiis_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [AW-1:0]            r_pos;
    logic [AW-1:0]            n_pos;
    logic                     r_valid;
    logic [1:0]               r_cnt;
    logic signed [CMD_W-1:0]  r_cmd;
    logic [AW-1:0]            r_addr [3];
    logic [1:0]               r_last_sel;

    logic [AW:0]              sum_second;
    logic [AW:0]              sum_third;
    logic [AW-1:0]            addr_second;
    logic [AW-1:0]            addr_third;
    logic [1:0]               last_sel;
    logic signed [AMP_W-1:0]  amp;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;

    always_comb begin
        sum_second = {1'b0, r_pos} + {1'b0, i_dly_second};
        sum_third = {1'b0, r_pos} + {1'b0, i_dly_third};
        if (sum_second >= (AW+1)'(BUFFER_DEPTH)) begin
            addr_second = AW'(sum_second - (AW+1)'(BUFFER_DEPTH));
        end else begin
            addr_second = sum_second[AW-1:0];
        end
        if (sum_third >= (AW+1)'(BUFFER_DEPTH)) begin
            addr_third = AW'(sum_third - (AW+1)'(BUFFER_DEPTH));
        end else begin
            addr_third = sum_third[AW-1:0];
        end
        if (r_pos == AW'(BUFFER_DEPTH - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + AW'(1);
        end
        // The last operation that touches the current slot emits it and clears it.
        if (addr_third == r_pos) begin
            last_sel = OP_THIRD;
        end else if (addr_second == r_pos) begin
            last_sel = OP_SECOND;
        end else begin
            last_sel = OP_FIRST;
        end
    end

    always_comb begin
        case (r_cnt)
            OP_FIRST:  amp = i_amp_first;
            OP_SECOND: amp = i_amp_second;
            default:   amp = i_amp_third;
        endcase
        prod = r_cmd * amp;
        rounded = prod + 32'sd8192;
    end

    assign o_can_take = !r_valid || (r_cnt == OP_THIRD);
    assign o_op.valid = r_valid;
    assign o_op.last = (r_cnt == r_last_sel);
    assign o_op.scaled = rounded[PROD_W-1:PROD_W-SCL_W];
    assign o_op_addr = r_addr[r_cnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_valid <= 1'b0;
            r_cnt <= OP_FIRST;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_valid <= 1'b1;
            r_cnt <= OP_FIRST;
        end else if (r_valid) begin
            if (r_cnt == OP_THIRD) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_command_in;
            r_addr[0] <= r_pos;
            r_addr[1] <= addr_second;
            r_addr[2] <= addr_third;
            r_last_sel <= last_sel;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tiis_acc.sv
`default_nettype none

module tiis_acc #(
    parameter int BUFFER_DEPTH = tiis_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tiis_pkg::t_op                     i_op,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0]   i_op_addr,
    output tiis_pkg::t_res                         o_res,
    output logic                                   o_clearing
);

    import tiis_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic signed [SLOT_W:0] SLOT_MAX = 20'sd262143;
    localparam logic signed [SLOT_W:0] SLOT_MIN = -20'sd262144;
    localparam logic signed [SLOT_W-1:0] OUT_MAX = 19'sd32767;
    localparam logic signed [SLOT_W-1:0] OUT_MIN = -19'sd32768;

    logic signed [SLOT_W-1:0] r_mem [BUFFER_DEPTH];
    logic signed [SLOT_W-1:0] r_rdata;

    logic                     r_m_valid;
    logic                     r_m_last;
    logic signed [SCL_W-1:0]  r_m_scaled;
    logic [AW-1:0]            r_m_addr;

    logic                     r_w_valid;
    logic [AW-1:0]            r_w_addr;
    logic signed [SLOT_W-1:0] r_w_data;

    logic                     r_clr_busy;
    logic [AW-1:0]            r_clr_addr;

    logic signed [SLOT_W-1:0] base;
    logic signed [SLOT_W:0]   sum;
    logic signed [SLOT_W-1:0] slot_sat;
    logic signed [SLOT_W-1:0] wdata;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [SLOT_W-1:0] mem_wdata;

    always_comb begin
        // The write of the previous operation lands on the same edge as this read.
        if (r_w_valid && (r_w_addr == r_m_addr)) begin
            base = r_w_data;
        end else begin
            base = r_rdata;
        end
        sum = (SLOT_W+1)'(base) + (SLOT_W+1)'(r_m_scaled);
        if (sum > SLOT_MAX) begin
            slot_sat = SLOT_MAX[SLOT_W-1:0];
        end else if (sum < SLOT_MIN) begin
            slot_sat = SLOT_MIN[SLOT_W-1:0];
        end else begin
            slot_sat = sum[SLOT_W-1:0];
        end
        wdata = r_m_last ? '0 : slot_sat;

        o_res.valid = r_m_valid && r_m_last;
        if (slot_sat > OUT_MAX) begin
            o_res.payload.command_out = 16'sd32767;
            o_res.payload.saturated = 1'b1;
        end else if (slot_sat < OUT_MIN) begin
            o_res.payload.command_out = -16'sd32768;
            o_res.payload.saturated = 1'b1;
        end else begin
            o_res.payload.command_out = slot_sat[CMD_W-1:0];
            o_res.payload.saturated = 1'b0;
        end

        we = r_clr_busy || r_m_valid;
        waddr = r_clr_busy ? r_clr_addr : r_m_addr;
        mem_wdata = r_clr_busy ? '0 : wdata;
    end

    assign o_clearing = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[i_op_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_m_valid <= i_op.valid;
            r_w_valid <= r_m_valid;
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_last <= i_op.last;
        r_m_scaled <= i_op.scaled;
        r_m_addr <= i_op_addr;
        r_w_addr <= r_m_addr;
        r_w_data <= wdata;
    end

endmodule

`default_nettype wire

// File: hdl/tiis_ofifo.sv
`default_nettype none

module tiis_ofifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tiis_pkg::t_res i_push,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tiis_pkg::t_out      o_data
);

    import tiis_pkg::*;

    t_out                r_buf [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wr_ptr;
    logic [OFIFO_AW-1:0] r_rd_ptr;
    logic [OFIFO_CW-1:0] r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_data = r_buf[r_rd_ptr];
    assign pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                if (r_wr_ptr == OFIFO_AW'(OFIFO_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + OFIFO_AW'(1);
                end
            end
            if (pop) begin
                if (r_rd_ptr == OFIFO_AW'(OFIFO_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + OFIFO_AW'(1);
                end
            end
            if (i_push.valid && !pop) begin
                r_count <= r_count + OFIFO_CW'(1);
            end else if (!i_push.valid && pop) begin
                r_count <= r_count - OFIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_buf[r_wr_ptr] <= i_push.payload;
        end
    end

endmodule

`default_nettype wire

// File: hdl/three_impulse_input_shaper_top.sv
// Three-impulse input shaper: each input request carries one signed velocity command and
// produces exactly one shaped, saturated command, in order. A request issues three
// read-modify-writes to the accumulation store, one per impulse, on its single read and
// single write port, so a new request is taken only once the previous one issues its third,
// when the output side keeps up; its result is emitted by whichever impulse is the last to
// land on the current slot, and waits in a small output queue, which limits the requests in
// flight to four. After reset the store is cleared one entry per cycle, all BUFFER_DEPTH
// entries, with input ready held low. Configuration registers may be written at any time
// while no request is in flight.
`default_nettype none

module three_impulse_input_shaper_top #(
    parameter int BUFFER_DEPTH = tiis_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [tiis_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tiis_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [tiis_pkg::CMD_W-1:0]      i_command_in,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [tiis_pkg::CMD_W-1:0]           o_command_out,
    output logic                                        o_saturated
);

    import tiis_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int DEPTH_W = 13;
    localparam int REM_W = DEPTH_W + DLY_W;

    function automatic logic [DEPTH_W-1:0] reduce_delay(
        input logic [DLY_W-1:0]   d,
        input logic [DEPTH_W-1:0] depth
    );
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] step;
        rem = REM_W'(d);
        for (int k = DLY_W - 1; k >= 0; k--) begin
            step = REM_W'(depth) << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[DEPTH_W-1:0];
    endfunction

    logic signed [AMP_W-1:0] r_amp_first;
    logic signed [AMP_W-1:0] r_amp_second;
    logic signed [AMP_W-1:0] r_amp_third;
    logic [AW-1:0]           r_dly_second;
    logic [AW-1:0]           r_dly_third;
    logic [OFIFO_CW-1:0]     r_outst;

    logic                    can_take;
    logic                    clearing;
    logic                    accept;
    logic                    pop;
    logic [AW-1:0]           cfg_dly;
    t_op                     op;
    logic [AW-1:0]           op_addr;
    t_res                    res;
    t_out                    out_data;

    assign cfg_dly = AW'(reduce_delay(i_cfg_data[DLY_W-1:0], DEPTH_W'(BUFFER_DEPTH)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_first <= AMP_FIRST_RST;
            r_amp_second <= AMP_SECOND_RST;
            r_amp_third <= AMP_THIRD_RST;
            r_dly_second <= AW'(reduce_delay(DELAY_SECOND_RST, DEPTH_W'(BUFFER_DEPTH)));
            r_dly_third <= AW'(reduce_delay(DELAY_THIRD_RST, DEPTH_W'(BUFFER_DEPTH)));
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_AMP_FIRST:    r_amp_first <= i_cfg_data;
                REG_AMP_SECOND:   r_amp_second <= i_cfg_data;
                REG_AMP_THIRD:    r_amp_third <= i_cfg_data;
                REG_DELAY_SECOND: r_dly_second <= cfg_dly;
                REG_DELAY_THIRD:  r_dly_third <= cfg_dly;
                default: ;
            endcase
        end
    end

    assign o_ready = can_take && !clearing && (r_outst < OFIFO_CW'(OFIFO_DEPTH));
    assign accept = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else if (accept && !pop) begin
            r_outst <= r_outst + OFIFO_CW'(1);
        end else if (!accept && pop) begin
            r_outst <= r_outst - OFIFO_CW'(1);
        end
    end

    tiis_seq #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command_in(i_command_in),
        .i_amp_first (r_amp_first),
        .i_amp_second(r_amp_second),
        .i_amp_third (r_amp_third),
        .i_dly_second(r_dly_second),
        .i_dly_third (r_dly_third),
        .o_can_take  (can_take),
        .o_op        (op),
        .o_op_addr   (op_addr)
    );

    tiis_acc #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_op_addr (op_addr),
        .o_res     (res),
        .o_clearing(clearing)
    );

    tiis_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res),
        .i_pop  (i_ready),
        .o_valid(o_valid),
        .o_data (out_data)
    );

    assign o_command_out = out_data.command_out;
    assign o_saturated = out_data.saturated;

endmodule

`default_nettype wire
